### sv/iwle_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the indexed word list engine.
// No dependencies; used by the cell, the read tree and the top level.
package iwle_pkg;

    localparam int KIND_W = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 64;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;
    localparam int GROUP  = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_SET    = 3'd4,
        KIND_GET    = 3'd5,
        KIND_COUNT  = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_OPEN  = 2'd2,
        CELL_CLOSE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     read;
    } cell_cmd_t;

endpackage

### sv/indexed_word_list_engine.sv
`timescale 1ns / 1ps
// Indexed word list engine: a bounded ordered list of words held in a row of cells, one word
// per cell. For push, pop, insert, remove, set and count the request is accepted, the cells
// that the request touches shift or load in parallel at that edge, and the result appears in the
// output register on the next cycle, so back-to-back requests run at one per cycle while the
// output is taken. A get runs in steps: the addressed cell registers its word, a registered
// OR tree merges groups of eight cells, and the merged word is sign extended into the output
// register; no new request is accepted during a get. Depends on iwle_pkg, iwle_cell and
// iwle_read_tree.
module indexed_word_list_engine #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [iwle_pkg::KIND_W-1:0]         kind,
    input  logic [iwle_pkg::POS_W-1:0]          position,
    input  logic signed [iwle_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [iwle_pkg::DATA_W-1:0]  read_word,
    output logic [iwle_pkg::LEN_W-1:0]          length,
    output logic [iwle_pkg::STAT_W-1:0]         status
);
    import iwle_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TREE,
        S_MERGE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic signed [DATA_W-1:0] read_word_reg;
    logic [LEN_W-1:0]     length_reg;
    status_t              status_reg;
    status_t              status_next;

    logic                 accept;
    logic                 get_ok;
    cell_cmd_t            cmd;
    logic [IDX_W-1:0]     cmd_pos;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] merged;
    logic signed [WORD_BITS-1:0] merged_s;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] cell_hit  [CAPACITY];

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign wdata    = WORD_BITS'(value);
    assign merged_s = merged;

    always_comb
    begin
        cmd.op      = CELL_HOLD;
        cmd.read    = 1'b0;
        cmd_pos     = IDX_W'(position);
        count_next  = count_reg;
        status_next = ST_DONE;
        get_ok      = 1'b0;
        unique case (kind)
            KIND_PUSH:
            begin
                cmd_pos = IDX_W'(count_reg);
                if (cnt_ext >= CAP_C)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = CELL_WRITE;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_INSERT:
            begin
                priority if (pos_ext > cnt_ext)
                begin
                    status_next = ST_REJECT;
                end
                else if (cnt_ext >= CAP_C)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = CELL_OPEN;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    cmd.op     = CELL_CLOSE;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_SET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    cmd.op = CELL_WRITE;
                end
            end
            KIND_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    cmd.read = 1'b1;
                    get_ok   = 1'b1;
                end
            end
            KIND_COUNT:
            begin
                status_next = ST_DONE;
            end
            default:
            begin
                status_next = ST_REJECT;
            end
        endcase
        if (!accept)
        begin
            cmd.op     = CELL_HOLD;
            cmd.read   = 1'b0;
            count_next = count_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[i+1];
            end
            iwle_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX_W     (IDX_W),
                .IDX       (i)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (cmd_pos),
                .wdata      (wdata),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[i]),
                .hit_word   (cell_hit[i])
            );
        end
    endgenerate

    iwle_read_tree #(
        .WORD_BITS (WORD_BITS),
        .CAPACITY  (CAPACITY)
    ) u_read_tree (
        .clk      (clk),
        .hit_word (cell_hit),
        .merged   (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            read_word_reg <= '0;
            length_reg    <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            count_reg <= count_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        length_reg <= LEN_W'(count_next);
                        status_reg <= status_next;
                        if (get_ok)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_TREE;
                        end
                        else
                        begin
                            read_word_reg <= '0;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    else if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_TREE:
                begin
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    read_word_reg <= DATA_W'(merged_s);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign read_word = read_word_reg;
    assign length    = length_reg;
    assign status    = status_reg;

endmodule

### sv/iwle_cell.sv
`timescale 1ns / 1ps
// One list slot: holds a word and trades it with its neighbors on open/close.
// Depends on iwle_pkg.
module iwle_cell #(
    parameter int WORD_BITS = 64,
    parameter int IDX_W     = 6,
    parameter int IDX       = 0
) (
    input  logic                 clk,
    input  iwle_pkg::cell_cmd_t  cmd,
    input  logic [IDX_W-1:0]     pos,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    output logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] hit_word
);
    import iwle_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [WORD_BITS-1:0] hit_reg;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                word_next = word_reg;
            end
            CELL_WRITE:
            begin
                if (MY_IDX == pos)
                begin
                    word_next = wdata;
                end
            end
            CELL_OPEN:
            begin
                if (MY_IDX == pos)
                begin
                    word_next = wdata;
                end
                else if (MY_IDX > pos)
                begin
                    word_next = left_word;
                end
            end
            CELL_CLOSE:
            begin
                if (MY_IDX >= pos)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        hit_reg  <= (cmd.read && (MY_IDX == pos)) ? word_reg : '0;
    end

    assign word     = word_reg;
    assign hit_word = hit_reg;

endmodule

### sv/iwle_read_tree.sv
`timescale 1ns / 1ps
// Registered OR tree that merges the per-cell read words into one word.
// Depends on iwle_pkg.
module iwle_read_tree #(
    parameter int WORD_BITS = 64,
    parameter int CAPACITY  = 64
) (
    input  logic                 clk,
    input  logic [WORD_BITS-1:0] hit_word [CAPACITY],
    output logic [WORD_BITS-1:0] merged
);
    import iwle_pkg::*;

    localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

    logic [WORD_BITS-1:0] grp_next [NGRP];
    logic [WORD_BITS-1:0] grp_reg  [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | hit_word[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            merged = merged | grp_reg[g];
        end
    end

endmodule
